FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cuckoo hash table check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cuckoo hash table check failed");

`endif

FILE: hw/rtl/cht_pkg.sv
// Types, constants and the slot hash of the cuckoo hash table.
package cht_pkg;

  localparam int unsigned SLOTS   = 4096;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KEY_W-1:0] MUL_FIRST  = 32'd2654435761;
  localparam logic [KEY_W-1:0] MUL_SECOND = 32'd2246822519;

  localparam logic [CFG_W-1:0]   FIRST_SEED_RST  = 32'd42;
  localparam logic [CFG_W-1:0]   SECOND_SEED_RST = 32'd123;
  localparam logic [LIMIT_W-1:0] KICK_LIMIT_RST  = 10'd500;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    OUT_MISS    = 3'd0,
    OUT_HIT     = 3'd1,
    OUT_UPDATED = 3'd2,
    OUT_STORED  = 3'd3,
    OUT_FAILED  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] new_value;
  } cht_in_t;

  typedef struct packed {
    outcome_e                outcome;
    logic signed [VAL_W-1:0] found_value;
  } cht_out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic     clear;
    logic     load;
    logic     hash;
    logic     read;
    logic     update;
    logic     place;
    logic     result;
    outcome_e outcome;
  } cht_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_insert;
    logic hit_a;
    logic hit_b;
    logic free;
    logic last;
    logic limit_zero;
    logic clr_last;
    logic out_free;
  } cht_sts_t;

  // SLOTS is a power of two, so only the low key bits reach the slot index:
  // the low bits of a product depend only on the low bits of its factors.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key,
                                                input logic [KEY_W-1:0] mul,
                                                input logic [SLOT_W-1:0] seed);
    logic [2*SLOT_W-1:0] prod;
    prod = key[SLOT_W-1:0] * mul[SLOT_W-1:0];
    return prod[SLOT_W-1:0] ^ seed;
  endfunction

endpackage

FILE: hw/rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cht_ctrl.sv
// Sequencer of the cuckoo hash table: clear pass, probes and displacement loop.
module cht_ctrl import cht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cht_sts_t sts_i,
  output cht_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_KHASH = 3'd5;
  localparam logic [2:0] ST_KREAD = 3'd6;
  localparam logic [2:0] ST_KICK  = 3'd7;

  logic [2:0] state_d, state_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.outcome = OUT_MISS;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts_i.is_insert) begin
          if (sts_i.out_free) begin
            cmd_o.result  = 1'b1;
            cmd_o.outcome = (sts_i.hit_a || sts_i.hit_b) ? OUT_HIT : OUT_MISS;
            state_d       = ST_IDLE;
          end
        end else if (sts_i.hit_a || sts_i.hit_b) begin
          if (sts_i.out_free) begin
            cmd_o.update  = 1'b1;
            cmd_o.result  = 1'b1;
            cmd_o.outcome = OUT_UPDATED;
            state_d       = ST_IDLE;
          end
        end else if (sts_i.limit_zero) begin
          if (sts_i.out_free) begin
            cmd_o.result  = 1'b1;
            cmd_o.outcome = OUT_FAILED;
            state_d       = ST_IDLE;
          end
        end else begin
          // First table slot of the new key is already read: place at once.
          state_d = ST_KICK;
        end
      end
      ST_KHASH: begin
        cmd_o.hash = 1'b1;
        state_d    = ST_KREAD;
      end
      ST_KREAD: begin
        cmd_o.read = 1'b1;
        state_d    = ST_KICK;
      end
      ST_KICK: begin
        if (sts_i.free || sts_i.last) begin
          // Hold the final write until the result register can take the beat.
          if (sts_i.out_free) begin
            cmd_o.place   = 1'b1;
            cmd_o.result  = 1'b1;
            cmd_o.outcome = sts_i.free ? OUT_STORED : OUT_FAILED;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = ST_KHASH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/cht_dp.sv
// Datapath of the cuckoo hash table: config, hashing, table RAMs, result register.
module cht_dp import cht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cht_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cht_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  cht_cmd_t             cmd_i,
  output cht_sts_t             sts_o
);

  // Only the low seed bits reach a slot index.
  logic [SLOT_W-1:0]  seed_a_q, seed_b_q;
  logic [LIMIT_W-1:0] limit_q;

  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [SLOT_W-1:0]  slot_a_q, slot_b_q;
  logic [LIMIT_W-1:0] cnt_q;
  logic               first_q;
  logic [SLOT_W-1:0]  clr_q;
  logic               out_valid_q;
  cht_out_t           out_data_q;

  entry_t            rd_a, rd_b, wr_entry;
  logic              we_a, we_b;
  logic [SLOT_W-1:0] waddr_a, waddr_b;
  logic              hit_a, hit_b;
  logic [LIMIT_W:0]  cnt_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= FIRST_SEED_RST[SLOT_W-1:0];
      seed_b_q <= SECOND_SEED_RST[SLOT_W-1:0];
      limit_q  <= KICK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_SEED:  seed_a_q <= cfg_wdata_i[SLOT_W-1:0];
        REG_SECOND_SEED: seed_b_q <= cfg_wdata_i[SLOT_W-1:0];
        REG_KICK_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Carried command, entry and slot pair.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_data_i.command;
      key_q <= in_data_i.lookup_key;
      val_q <= in_data_i.new_value;
    end else if (cmd_i.place) begin
      key_q <= first_q ? rd_a.key : rd_b.key;
      val_q <= first_q ? rd_a.value : rd_b.value;
    end
    if (cmd_i.hash) begin
      slot_a_q <= slot_of(key_q, MUL_FIRST, seed_a_q);
      slot_b_q <= slot_of(key_q, MUL_SECOND, seed_b_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      first_q     <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q   <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.place) begin
        cnt_q   <= cnt_next[LIMIT_W-1:0];
        first_q <= !first_q;
      end
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      out_data_q.outcome     <= cmd_i.outcome;
      out_data_q.found_value <= (cmd_i.outcome == OUT_HIT) ?
                                (hit_a ? rd_a.value : rd_b.value) : '0;
    end
  end

  assign cnt_next = {1'b0, cnt_q} + 1'b1;
  assign hit_a    = rd_a.valid && (rd_a.key == key_q);
  assign hit_b    = rd_b.valid && (rd_b.key == key_q);

  // Clear pass writes invalid entries; update and place write the carried pair.
  always_comb begin
    wr_entry = cmd_i.clear ? entry_t'('0) : entry_t'{valid: 1'b1, key: key_q, value: val_q};
    waddr_a  = cmd_i.clear ? clr_q : slot_a_q;
    waddr_b  = cmd_i.clear ? clr_q : slot_b_q;
    we_a     = cmd_i.clear || (cmd_i.update && hit_a) || (cmd_i.place && first_q);
    we_b     = cmd_i.clear || (cmd_i.update && !hit_a) || (cmd_i.place && !first_q);
  end

  cht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr_a),
    .wdata_i(wr_entry),
    .re_i   (cmd_i.read),
    .raddr_i(slot_a_q),
    .rdata_o(rd_a)
  );

  cht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr_b),
    .wdata_i(wr_entry),
    .re_i   (cmd_i.read),
    .raddr_i(slot_b_q),
    .rdata_o(rd_b)
  );

  always_comb begin
    sts_o.is_insert  = cmd_q;
    sts_o.hit_a      = hit_a;
    sts_o.hit_b      = hit_b;
    sts_o.free       = first_q ? !rd_a.valid : !rd_b.valid;
    sts_o.last       = (cnt_next == {1'b0, limit_q});
    sts_o.limit_zero = (limit_q == '0);
    sts_o.clr_last   = (clr_q == SLOT_W'(SLOTS - 1));
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/cuckoo_hash_table.sv
// Two-table cuckoo hash map of 32-bit keys to 32-bit values.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is a search
// or an insert-or-update. Output channel (out_valid_o / out_stall_i /
// out_data_o): exactly one result beat per input beat, in order.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 first seed, 1 second seed, 2 kick limit); write only while idle.
// After reset the block runs a clearing pass over all 4096 slots of both
// tables with in_stall_o high; config writes are taken during it.
// One item is in work at a time. A search, an update and an insert refused
// by a zero kick limit pass through hash, RAM read and check before the
// result is registered; placing a new key adds a write step, and every
// displacement adds a rehash, a read and a write, up to the kick limit.
// The next beat is taken while the result first shows on out_valid_o, and
// the single RAM read port per table sets the pace of these steps.
// A result waits in the output register while out_stall_i is high; the
// next item is accepted meanwhile and holds at its final step until the
// register frees.
module cuckoo_hash_table import cht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cht_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cht_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cht_cmd_t cmd;
  cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cht_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: hw/rtl/cht_checker.sv
// Port-level checks of the cuckoo hash table and their bind.
`include "assert_macros.svh"

module cht_checker import cht_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input cht_out_t             out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // One item at a time: an accepted beat blocks the input.
  `CHT_ASSERT_NEXT(busy_after_accept, in_beat, in_stall_o)
  // Hash and read take cycles: no result right after an accept.
  `CHT_ASSERT_NEXT(no_instant_result, in_beat, !$rose(out_valid_o))
  // A new result ends its item: the input opens again.
  `CHT_ASSERT(idle_on_result, $rose(out_valid_o), !in_stall_o)
  `CHT_ASSERT_NEXT(out_hold_valid, out_valid_o && out_stall_i, out_valid_o)
  `CHT_ASSERT_NEXT(out_hold_data, out_valid_o && out_stall_i, $stable(out_data_o))

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/tb_cuckoo_hash_table.sv
// Self-checking testbench for the two-table cuckoo hash map.
module tb_cuckoo_hash_table;
  import cht_pkg::*;

  localparam logic                 CMD_SEARCH = 1'b0;
  localparam logic                 CMD_INSERT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned          WATCHDOG_LIMIT = 20000;
  localparam int unsigned          KEY_HISTORY = 64;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cht_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cht_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  cuckoo_hash_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Mirror of the table contents and the register settings
  logic [KEY_W-1:0]   slot_key  [2][SLOTS];
  logic [VAL_W-1:0]   slot_val  [2][SLOTS];
  bit                 slot_full [2][SLOTS];
  logic [CFG_W-1:0]   seed_m [2] = '{FIRST_SEED_RST, SECOND_SEED_RST};
  logic [LIMIT_W-1:0] kicks_m = KICK_LIMIT_RST;

  cht_in_t  cmd_q [$];
  cht_out_t due_results [$];
  logic [KEY_W-1:0] known_keys [$];
  logic [SLOT_W-1:0] bucket_pool [16];
  logic [KEY_W-1:0] corner_keys [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF};

  int unsigned items_queued = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          idling = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SLOT_W-1:0] slot_index(logic [KEY_W-1:0] key, int side);
    logic [KEY_W-1:0] mixed;
    mixed = (key * (side == 0 ? MUL_FIRST : MUL_SECOND)) ^ seed_m[side];
    return SLOT_W'(mixed % SLOTS);
  endfunction

  // Search, update in place, or place with displacement; returns the result beat.
  function automatic cht_out_t cuckoo_apply(cht_in_t item);
    cht_out_t          res;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  carry_key;
    logic [KEY_W-1:0]  bump_key;
    logic [VAL_W-1:0]  carry_val;
    logic [VAL_W-1:0]  bump_val;
    logic [SLOT_W-1:0] home [2];
    logic [SLOT_W-1:0] s;
    bit                was_full;
    int                side;
    int                tries;
    key = item.lookup_key;
    res.outcome = OUT_MISS;
    res.found_value = '0;
    home[0] = slot_index(key, 0);
    home[1] = slot_index(key, 1);
    if (slot_full[0][home[0]] && slot_key[0][home[0]] == key) side = 0;
    else if (slot_full[1][home[1]] && slot_key[1][home[1]] == key) side = 1;
    else side = -1;
    if (side >= 0) begin
      if (item.command == CMD_SEARCH) begin
        res.outcome = OUT_HIT;
        res.found_value = slot_val[side][home[side]];
      end else begin
        slot_val[side][home[side]] = item.new_value;
        res.outcome = OUT_UPDATED;
      end
    end else if (item.command == CMD_INSERT) begin
      // Alternate tables starting with the first; drop whatever is carried at the end
      res.outcome = OUT_FAILED;
      carry_key = key;
      carry_val = item.new_value;
      side = 0;
      for (tries = 0; tries < kicks_m; tries++) begin
        s = slot_index(carry_key, side);
        bump_key = slot_key[side][s];
        bump_val = slot_val[side][s];
        was_full = slot_full[side][s];
        slot_key[side][s] = carry_key;
        slot_val[side][s] = carry_val;
        slot_full[side][s] = 1'b1;
        if (!was_full) begin
          res.outcome = OUT_STORED;
          break;
        end
        carry_key = bump_key;
        carry_val = bump_val;
        side = 1 - side;
      end
    end
    return res;
  endfunction

  function automatic cht_in_t random_item();
    cht_in_t          it;
    logic [KEY_W-1:0] k;
    int               pick;
    bit               reused;
    pick = $urandom_range(0, 19);
    reused = 1'b0;
    k = $urandom();
    if (pick < 9 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      reused = 1'b1;
    end else if (pick < 15) begin
      // Crowd a few slot pairs so that displacement chains and failures occur
      k[SLOT_W-1:0] = bucket_pool[$urandom_range(0, 15)];
    end else if (pick == 15) begin
      k = corner_keys[$urandom_range(0, 3)];
    end
    it.command = 1'($urandom_range(0, 1));
    it.lookup_key = k;
    it.new_value = ($urandom_range(0, 15) == 0) ? '1 : $urandom();
    if (!reused && it.command == CMD_INSERT) begin
      known_keys.push_back(k);
      if (known_keys.size() > KEY_HISTORY) void'(known_keys.pop_front());
    end
    return it;
  endfunction

  task automatic queue_op(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    cht_in_t it;
    it.command = cmd;
    it.lookup_key = key;
    it.new_value = val;
    cmd_q.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FIRST_SEED:  seed_m[0] = data;
      REG_SECOND_SEED: seed_m[1] = data;
      REG_KICK_LIMIT:  kicks_m = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item has been taken and answered.
  task automatic settle();
    while (accepted_cnt != items_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] s0, logic [CFG_W-1:0] s1,
                           logic [CFG_W-1:0] kicks, int count, bit idle_on);
    settle();
    write_reg(REG_FIRST_SEED, s0);
    write_reg(REG_SECOND_SEED, s1);
    write_reg(REG_KICK_LIMIT, kicks);
    idling = idle_on;
    for (int n = 0; n < count; n++) begin
      cmd_q.push_back(random_item());
      items_queued++;
    end
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch in %s of result %0d: expected %h, got %h",
               field, results_checked, want, got);
  endtask

  task automatic check_result(cht_out_t got);
    cht_out_t want;
    if (due_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected result beat: outcome %0d, value %h",
                 got.outcome, got.found_value);
    end else begin
      want = due_results.pop_front();
      if (got.outcome !== want.outcome)
        note_mismatch("outcome", 32'(want.outcome), 32'(got.outcome));
      if (got.found_value !== want.found_value)
        note_mismatch("found_value", want.found_value, got.found_value);
    end
    results_checked++;
  endtask

  // Driver: predict on each accepted beat, then offer the next one or idle
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(cuckoo_apply(in_data));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) gap_left--;
        else if (idling && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 14);
        if (gap_left == 0 && cmd_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat and apply stall bursts
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (stall_left > 0) stall_left--;
      else if (idling && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL cuckoo_hash_table");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] crowd;
    crowd = 32'h0000_0ABC;
    bucket_pool[0] = '0;
    bucket_pool[15] = '1;
    for (int i = 1; i < 15; i++) bucket_pool[i] = SLOT_W'($urandom());

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Written during the clearing pass
    write_reg(REG_FIRST_SEED, '0);
    write_reg(REG_SECOND_SEED, '1);
    write_reg(REG_KICK_LIMIT, KICK_LIMIT_RST);
    idling = 1'b1;

    queue_op(CMD_SEARCH, 32'h0000_0000, 32'h1111_1111);
    queue_op(CMD_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_op(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000);
    queue_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
    queue_op(CMD_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_op(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0005);
    queue_op(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    // Same low bits hit the same slot pair: evict into the second table, then overflow
    queue_op(CMD_INSERT, crowd, 32'hA000_0001);
    queue_op(CMD_INSERT, crowd + 32'h1000, 32'hA000_0002);
    queue_op(CMD_SEARCH, crowd, 32'h0);
    queue_op(CMD_SEARCH, crowd + 32'h1000, 32'h0);
    queue_op(CMD_INSERT, crowd, 32'hB000_0001);
    queue_op(CMD_INSERT, crowd + 32'h2000, 32'hA000_0003);
    queue_op(CMD_SEARCH, crowd, 32'h0);
    queue_op(CMD_SEARCH, crowd + 32'h1000, 32'h0);
    queue_op(CMD_SEARCH, crowd + 32'h2000, 32'h0);

    // Zero kick limit: new keys fail outright, present keys still update
    settle();
    write_reg(REG_KICK_LIMIT, '0);
    queue_op(CMD_INSERT, 32'h1234_5678, 32'hCAFE_0000);
    queue_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0001);
    queue_op(CMD_SEARCH, 32'h0000_0000, 32'h0);
    queue_op(CMD_SEARCH, 32'h1234_5678, 32'h0);

    // Unused index is ignored; bits above the limit field drop off
    settle();
    write_reg(REG_UNUSED, 32'h1234_5678);
    write_reg(REG_KICK_LIMIT, '1);
    queue_op(CMD_INSERT, crowd + 32'h3000, 32'hA000_0004);
    queue_op(CMD_SEARCH, 32'h8000_0000, 32'h0);

    run_phase($urandom(), $urandom(), $urandom_range(2, 12), 120, 1'b1);
    // Sender holds until the block has drained
    settle();
    for (int n = 0; n < 130; n++) begin
      cmd_q.push_back(random_item());
      items_queued++;
    end
    run_phase('0, '0, 1, 150, 1'b1);
    run_phase('1, '1, 1023, 120, 1'b0);
    run_phase($urandom(), $urandom(), $urandom_range(16, 64), 300, 1'b1);
    run_phase($urandom(), $urandom(), KICK_LIMIT_RST, 300, 1'b0);

    settle();
    repeat (64) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("PASS cuckoo_hash_table");
    end else begin
      $display("FAIL cuckoo_hash_table");
    end
    $finish;
  end

endmodule
